>>> hdl/k_group_reverse_reorder_assert.svh
// ----------------------------------------------------------------------------
// k_group_reverse_reorder assertion macros
// Concurrent check wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef K_GROUP_REVERSE_REORDER_ASSERT_SVH
`define K_GROUP_REVERSE_REORDER_ASSERT_SVH
`ifndef SYNTH
`define KGRR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kgrr assertion failed");
`define KGRR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kgrr assertion failed");
`else
`define KGRR_ASSERT_IMP(lbl, ante, cons)
`define KGRR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/kgrr_pkg.sv
// ----------------------------------------------------------------------------
// kgrr_pkg
// Shared widths, defaults and the chain shift control type.
// ----------------------------------------------------------------------------
package kgrr_pkg;

	localparam int VALUE_W       = 32;
	localparam int GSIZE_W       = 5;
	localparam int MAX_GROUP_DEF = 16;

	// shift control for the row of cells
	typedef struct packed {
		logic push;	// shift towards higher index, new value into cell 0
		logic pop;	// shift towards lower index, cell 0 leaves
	} kgrr_shift_t;

endpackage

>>> hdl/k_group_reverse_reorder.sv
// ----------------------------------------------------------------------------
// k_group_reverse_reorder
// Reverses a value stream in groups of group_size values; an incomplete final group keeps its order.
// ----------------------------------------------------------------------------
// Input channel (value, list_end, in_valid/in_stall) takes one element per
// transfer. Each element is pushed into a row of cells. When held plus new
// values reach group_size, the group drains newest first; when list_end
// arrives with an incomplete group, it drains in arrival order.
// Output channel (out_value, run_last, end_of_list, out_valid/out_stall)
// gives one result per transfer from an output register.
// A draining element's input transfer sets state_q; its first result is
// then loaded into the output register. A group drains one value per
// cycle while the receiver does not stall, from cell 0 when reversed and
// through the tap in arrival order; in_stall is high during the drain.
// Elements that only fill the row leave in_stall low.
// Config (cfg_data, cfg_valid/cfg_ready) is always ready; write it idle.
// Reset clears the held count and sets group_size to 1. A stalled receiver
// holds the output register and pauses the drain.
// ----------------------------------------------------------------------------
`include "k_group_reverse_reorder_assert.svh"

module k_group_reverse_reorder
	import kgrr_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      list_end,
	input  logic                      in_valid,
	output logic                      in_stall,
	output logic signed [VALUE_W-1:0] out_value,
	output logic                      run_last,
	output logic                      end_of_list,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  logic [GSIZE_W-1:0]        cfg_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready
);

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REV,
		ST_FWD
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             cnt_q;
	logic                      end_q;
	logic [GSIZE_W-1:0]        gsize_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      run_last_q;
	logic                      end_of_list_q;

	logic                      in_xfer;
	logic                      out_free;
	logic                      drain_go;
	logic [CW-1:0]             total;
	logic [CW-1:0]             eff_g;
	logic [CW-1:0]             cnt_m1;
	kgrr_shift_t               shift;
	logic signed [VALUE_W-1:0] head;
	logic signed [VALUE_W-1:0] tap;

	// zero means pass-through, oversize saturates
	always_comb begin
		if (gsize_q == '0) begin
			eff_g = CW'(1);
		end else if (32'(gsize_q) > MAX_GROUP) begin
			eff_g = CW'(MAX_GROUP);
		end else begin
			eff_g = CW'(gsize_q);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign drain_go  = (state_q != ST_IDLE) && out_free;
	assign total     = cnt_q + CW'(1);
	assign cnt_m1    = cnt_q - CW'(1);
	assign cfg_ready = 1'b1;

	assign shift.push = in_xfer;
	assign shift.pop  = drain_go && (state_q == ST_REV);

	kgrr_chain #(
		.MAX_GROUP (MAX_GROUP),
		.IW        (IW)
	) u_chain (
		.clk        (clk),
		.shift      (shift),
		.push_value (value),
		.rd_idx     (cnt_m1[IW-1:0]),
		.head       (head),
		.tap        (tap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= GSIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			gsize_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q <= total;
						end_q <= list_end;
						if (total >= eff_g) begin
							state_q <= ST_REV;
						end else if (list_end) begin
							state_q <= ST_FWD;
						end
					end
				end
				ST_REV, ST_FWD: begin
					if (drain_go) begin
						cnt_q <= cnt_m1;
						if (cnt_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (drain_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on each drain step
	always_ff @(posedge clk) begin
		if (drain_go) begin
			out_value_q   <= (state_q == ST_REV) ? head : tap;
			run_last_q    <= (cnt_q == CW'(1));
			end_of_list_q <= (cnt_q == CW'(1)) && end_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign run_last    = run_last_q;
	assign end_of_list = end_of_list_q;

	`KGRR_ASSERT_IMP(a_drain_cnt, state_q != ST_IDLE, cnt_q != '0)
	`KGRR_ASSERT_IMP(a_idle_cnt, state_q == ST_IDLE, 32'(cnt_q) < MAX_GROUP)
	`KGRR_ASSERT_IMP(a_end_last, out_valid_q && end_of_list_q, run_last_q)
	`KGRR_ASSERT_NXT(a_group_rev, in_xfer && (total >= eff_g), state_q == ST_REV)

endmodule

>>> hdl/kgrr_cell.sv
// ----------------------------------------------------------------------------
// kgrr_cell
// One storage cell of the value chain; loads from either neighbour.
// ----------------------------------------------------------------------------
module kgrr_cell
	import kgrr_pkg::*;
(
	input  logic                      clk,
	input  kgrr_shift_t               shift,
	input  logic signed [VALUE_W-1:0] up_in,
	input  logic signed [VALUE_W-1:0] dn_in,
	output logic signed [VALUE_W-1:0] q
);

	logic signed [VALUE_W-1:0] val_q;

	// push and pop never coincide; neither means hold
	always_ff @(posedge clk) begin
		if (shift.push) begin
			val_q <= up_in;
		end else if (shift.pop) begin
			val_q <= dn_in;
		end
	end

	assign q = val_q;

endmodule

>>> hdl/kgrr_chain.sv
// ----------------------------------------------------------------------------
// kgrr_chain
// Row of cells: newest value at cell 0, older values further up the row.
// ----------------------------------------------------------------------------
module kgrr_chain
	import kgrr_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF,
	parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  logic                      clk,
	input  kgrr_shift_t               shift,
	input  logic signed [VALUE_W-1:0] push_value,
	input  logic [IW-1:0]             rd_idx,
	output logic signed [VALUE_W-1:0] head,
	output logic signed [VALUE_W-1:0] tap
);

	logic signed [VALUE_W-1:0] cq [MAX_GROUP];

	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		logic signed [VALUE_W-1:0] up_w;
		logic signed [VALUE_W-1:0] dn_w;

		if (i == 0) begin : g_first
			assign up_w = push_value;
		end else begin : g_mid
			assign up_w = cq[i-1];
		end

		if (i == MAX_GROUP - 1) begin : g_last
			assign dn_w = cq[i];
		end else begin : g_inner
			assign dn_w = cq[i+1];
		end

		kgrr_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.up_in (up_w),
			.dn_in (dn_w),
			.q     (cq[i])
		);
	end

	assign head = cq[0];
	assign tap  = cq[rd_idx];

endmodule
